>>> src/ihex_enc_pkg.sv
// Shared types, codes and character tables for the Intel HEX record encoder.
// No dependencies; imported by the controller, datapath and top level.
package ihex_enc_pkg;

	localparam int MAX_RECORD_BYTES = 16;
	localparam int CNT_W            = 5;
	localparam int IDX_W            = $clog2(MAX_RECORD_BYTES);
	localparam int POS_W            = 6;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 5;

	localparam logic [1:0] ACT_DATA = 2'd0;
	localparam logic [1:0] ACT_ADDR = 2'd1;
	localparam logic [1:0] ACT_EOF  = 2'd2;
	localparam logic [1:0] ACT_EXT  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_RECORD_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EOF_STYLE     = 2'd1;

	localparam logic [POS_W-1:0] EOF_LAST_POS = 6'd12;
	localparam logic [POS_W-1:0] EXT_LAST_POS = 6'd15;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SUB   = 8'h1A;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic [15:0] load_address;
	} in_item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic latch;
		logic store;
		logic emit;
		logic tail_sel;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] new_action;
		logic [1:0] item_action;
		logic       count_zero;
		logic       full_next;
		logic       out_free;
		logic       rec_end;
		logic       tail_end;
	} dp_stat_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = CH_ZERO + {4'b0, nib};
		end else begin
			c = CH_ZERO + 8'd7 + {4'b0, nib};
		end
		return c;
	endfunction

	// End-of-file strings and the extended address record, by position.
	function automatic logic [7:0] tail_char(input logic is_ext, input logic style,
			input logic [3:0] idx);
		logic [7:0] c;
		if (is_ext) begin
			unique case (idx)
				4'd0:    c = CH_COLON;
				4'd2:    c = CH_TWO;
				4'd8:    c = CH_FOUR;
				4'd13:   c = CH_F;
				4'd14:   c = CH_A;
				4'd15:   c = CH_LF;
				default: c = CH_ZERO;
			endcase
		end else begin
			unique case (idx)
				4'd0:         c = CH_COLON;
				4'd8:         c = style ? CH_ONE : CH_ZERO;
				4'd9, 4'd10:  c = style ? CH_F : CH_ZERO;
				4'd11:        c = CH_LF;
				4'd12:        c = CH_SUB;
				default:      c = CH_ZERO;
			endcase
		end
		return c;
	endfunction

endpackage

>>> src/ihex_enc_dpath.sv
// Datapath: record buffer, address/sum/count state, config registers,
// character generation and the output register. Depends on ihex_enc_pkg.
module ihex_enc_dpath import ihex_enc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  in_item_t              in_item,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic                  out_stall,
	output logic                  out_valid,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	in_item_t         item_q;
	logic [7:0]       mem_q [MAX_RECORD_BYTES];
	logic [CNT_W-1:0] count_q;
	logic [15:0]      raddr_q;
	logic [15:0]      naddr_q;
	logic [7:0]       sum_q;
	logic [CNT_W-1:0] reclen_q;
	logic             eof_style_q;
	logic [POS_W-1:0] pos_q;
	logic             ovalid_q;
	logic [7:0]       ochar_q;
	logic             olast_q;

	logic [CNT_W-1:0] limit;
	logic [POS_W-1:0] rec_last;
	logic [POS_W-1:0] data_off;
	logic [7:0]       data_val;
	logic [7:0]       chk;
	logic [7:0]       rec_char;
	logic [7:0]       emit_char;
	logic             emit_last;
	logic             rec_end;
	logic             tail_end;
	logic             is_ext;
	logic [15:0]      new_addr;

	always_comb begin
		if (reclen_q == '0) begin
			limit = CNT_W'(1);
		end else if (reclen_q > CNT_W'(MAX_RECORD_BYTES)) begin
			limit = CNT_W'(MAX_RECORD_BYTES);
		end else begin
			limit = reclen_q;
		end
	end

	assign is_ext   = (item_q.action == ACT_EXT);
	assign rec_last = POS_W'(11) + {count_q, 1'b0};
	assign rec_end  = (pos_q == rec_last);
	assign tail_end = (pos_q == (is_ext ? EXT_LAST_POS : EOF_LAST_POS));
	assign data_off = pos_q - POS_W'(9);
	assign data_val = mem_q[data_off[IDX_W:1]];
	assign chk      = 8'd0 - (sum_q + {3'b0, count_q});

	always_comb begin
		priority if (pos_q == POS_W'(0)) begin
			rec_char = CH_COLON;
		end else if (pos_q == POS_W'(1)) begin
			rec_char = hex_char({3'b0, count_q[4]});
		end else if (pos_q == POS_W'(2)) begin
			rec_char = hex_char(count_q[3:0]);
		end else if (pos_q == POS_W'(3)) begin
			rec_char = hex_char(raddr_q[15:12]);
		end else if (pos_q == POS_W'(4)) begin
			rec_char = hex_char(raddr_q[11:8]);
		end else if (pos_q == POS_W'(5)) begin
			rec_char = hex_char(raddr_q[7:4]);
		end else if (pos_q == POS_W'(6)) begin
			rec_char = hex_char(raddr_q[3:0]);
		end else if (pos_q == POS_W'(7) || pos_q == POS_W'(8)) begin
			rec_char = CH_ZERO;
		end else if (rec_end) begin
			rec_char = CH_LF;
		end else if (pos_q == rec_last - POS_W'(1)) begin
			rec_char = hex_char(chk[3:0]);
		end else if (pos_q == rec_last - POS_W'(2)) begin
			rec_char = hex_char(chk[7:4]);
		end else begin
			rec_char = hex_char(data_off[0] ? data_val[3:0] : data_val[7:4]);
		end
	end

	assign emit_char = cmd.tail_sel ? tail_char(is_ext, eof_style_q, pos_q[3:0]) : rec_char;
	assign emit_last = cmd.tail_sel ? tail_end :
		(rec_end && (item_q.action == ACT_DATA || item_q.action == ACT_ADDR));

	always_comb begin
		unique case (item_q.action)
			ACT_DATA: new_addr = naddr_q;
			ACT_ADDR: new_addr = item_q.load_address;
			default:  new_addr = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			raddr_q     <= '0;
			naddr_q     <= '0;
			sum_q       <= '0;
			reclen_q    <= CNT_W'(MAX_RECORD_BYTES);
			eof_style_q <= 1'b0;
			pos_q       <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RECORD_LENGTH: reclen_q    <= cfg_data;
					REG_EOF_STYLE:     eof_style_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.latch || cmd.finish) begin
				pos_q <= '0;
			end else if (cmd.emit) begin
				pos_q <= pos_q + POS_W'(1);
			end
			if (cmd.store) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + item_q.data_byte;
				naddr_q <= naddr_q + 16'd1;
			end
			if (cmd.finish) begin
				count_q <= '0;
				raddr_q <= new_addr;
				sum_q   <= new_addr[15:8] + new_addr[7:0];
				if (item_q.action == ACT_ADDR) begin
					naddr_q <= item_q.load_address;
				end
			end
			if (cmd.emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_item;
		end
		if (cmd.store) begin
			mem_q[count_q[IDX_W-1:0]] <= item_q.data_byte;
		end
		if (cmd.emit) begin
			ochar_q <= emit_char;
			olast_q <= emit_last;
		end
	end

	assign stat.new_action  = in_item.action;
	assign stat.item_action = item_q.action;
	assign stat.count_zero  = (count_q == '0);
	assign stat.full_next   = ((count_q + CNT_W'(1)) >= limit);
	assign stat.out_free    = !ovalid_q || !out_stall;
	assign stat.rec_end     = rec_end;
	assign stat.tail_end    = tail_end;

	assign out_valid             = ovalid_q;
	assign out_item.character    = ochar_q;
	assign out_item.last_of_run  = olast_q;

endmodule

>>> src/ihex_enc_ctrl.sv
// Controller state machine: sequences store, record emission, flush and
// trailing string per request. Depends on ihex_enc_pkg.
module ihex_enc_ctrl import ihex_enc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STORE,
		ST_REC,
		ST_FIN,
		ST_TAIL
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					if (stat.new_action == ACT_DATA) begin
						state_d = ST_STORE;
					end else if (stat.count_zero) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_REC;
					end
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = stat.full_next ? ST_REC : ST_IDLE;
			end
			ST_REC: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.rec_end) begin
						state_d = ST_FIN;
					end
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				if (stat.item_action == ACT_EOF || stat.item_action == ACT_EXT) begin
					state_d = ST_TAIL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TAIL: begin
				cmd.tail_sel = 1'b1;
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.tail_end) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

>>> src/intel_hex_record_encoder_unit.sv
// Intel HEX record encoder, top level: controller plus datapath.
// Depends on ihex_enc_pkg, ihex_enc_ctrl and ihex_enc_dpath.
//
// Input channel in_valid/in_stall/in_item takes one request at a time:
// a data byte, an address (flush), end of file or extended address record.
// Output channel out_valid/out_stall/out_item gives one ASCII character
// a cycle unless stalled; last_of_run marks a request's final character.
// Config channel cfg_valid/cfg_ready (always ready) writes record_length
// (index 0) and eof_style (index 1); write only while idle.
// A data byte that does not complete a record is latched, then stored.
// A record of n bytes is 12 + 2n characters and is followed by a flush
// state; the end-of-file string is 13 characters, the extended record 16.
// The controller's emit states make characters one per cycle unless stalled.
// in_stall stays high while a request is worked on: it drops once the
// last character is in the output register and any flush state is done.
// A stalled receiver holds the output register and pauses emission.
// Reset clears counts, addresses, sum and config to defaults
// (record_length 16, eof_style 0); the byte buffer is not cleared.
module intel_hex_record_encoder_unit import ihex_enc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	ihex_enc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	ihex_enc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted but block not busy next cycle");

	a_idle_holds_last: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall && out_valid |-> out_item.last_of_run)
		else $error("block idle while a non-final character is pending");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for intel_hex_record_encoder_unit: directed and random
// requests, random stalls on both sides, character-by-character output checks.
// Depends on ihex_enc_pkg and the encoder RTL.
module tb_top;
	import ihex_enc_pkg::*;

	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASES        = 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	intel_hex_record_encoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// encoder state mirror
	logic [7:0]  rec_data [MAX_RECORD_BYTES];
	logic [4:0]  rec_count = '0;
	logic [15:0] rec_start = '0;
	logic [15:0] addr_next = '0;
	logic [7:0]  rec_sum   = '0;
	logic [4:0]  len_reg   = 5'd16;
	logic        eof_reg   = 1'b0;

	logic [7:0] line_chars [$];
	out_item_t  exp_chars [$];
	in_item_t   pend_req [$];

	logic      in_taken  = 1'b0;
	int        in_gap    = 0;
	int        rx_wait   = 0;
	logic      steady    = 1'b0;
	logic      hold_req  = 1'b0;
	logic      hold_done = 1'b0;
	out_item_t want;

	int n_reqs = 0;
	int n_chars = 0;
	int n_records = 0;
	int n_eof = 0;
	int n_ext = 0;
	int n_errors = 0;
	int idle_cycles = 0;

	function automatic logic [7:0] hex_ascii(input logic [3:0] v);
		if (v < 4'd10) begin
			return CH_ZERO + {4'h0, v};
		end
		return CH_A + {4'h0, v} - 8'd10;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic log_error(input string msg);
		n_errors++;
		if (n_errors <= 10) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	task automatic put_hex_byte(input logic [7:0] b);
		line_chars.push_back(hex_ascii(b[7:4]));
		line_chars.push_back(hex_ascii(b[3:0]));
	endtask

	task automatic put_string(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_chars.push_back(s[i]);
		end
	endtask

	task automatic close_record(input logic [15:0] addr);
		logic [7:0] chk;
		if (rec_count != '0) begin
			chk = 8'd0 - (rec_sum + {3'b0, rec_count});
			line_chars.push_back(CH_COLON);
			put_hex_byte({3'b0, rec_count});
			put_hex_byte(rec_start[15:8]);
			put_hex_byte(rec_start[7:0]);
			put_hex_byte(8'h00);
			for (int i = 0; i < int'(rec_count); i++) begin
				put_hex_byte(rec_data[i]);
			end
			put_hex_byte(chk);
			line_chars.push_back(CH_LF);
			n_records++;
		end
		rec_count = '0;
		rec_start = addr;
		rec_sum   = addr[15:8] + addr[7:0];
	endtask

	// Expected text for one request, queued with last_of_run on its final character.
	task automatic encode_request(input in_item_t req);
		logic [4:0] lim;
		out_item_t  o;
		if (len_reg == '0) begin
			lim = 5'd1;
		end else if (len_reg > 5'd16) begin
			lim = 5'(MAX_RECORD_BYTES);
		end else begin
			lim = len_reg;
		end
		line_chars.delete();
		case (req.action)
			ACT_DATA: begin
				if (rec_count < 5'd16) begin
					rec_data[rec_count[3:0]] = req.data_byte;
					rec_count = rec_count + 5'd1;
				end
				rec_sum   = rec_sum + req.data_byte;
				addr_next = addr_next + 16'd1;
				if (rec_count >= lim) begin
					close_record(addr_next);
				end
			end
			ACT_ADDR: begin
				close_record(req.load_address);
				addr_next = req.load_address;
			end
			ACT_EOF: begin
				close_record(16'h0000);
				if (eof_reg) begin
					put_string(":00000001FF\n");
				end else begin
					put_string(":0000000000\n");
				end
				line_chars.push_back(CH_SUB);
				n_eof++;
			end
			ACT_EXT: begin
				close_record(16'h0000);
				put_string(":020000040000FA\n");
				n_ext++;
			end
		endcase
		foreach (line_chars[i]) begin
			o.character   = line_chars[i];
			o.last_of_run = (i == line_chars.size() - 1);
			exp_chars.push_back(o);
		end
	endtask

	task automatic queue_req(input logic [1:0] act, input logic [7:0] b,
			input logic [15:0] a);
		in_item_t r;
		r.action       = act;
		r.data_byte    = b;
		r.load_address = a;
		pend_req.push_back(r);
	endtask

	task automatic queue_random(input int count);
		in_item_t r;
		int       pick;
		for (int i = 0; i < count; i++) begin
			pick           = $urandom_range(0, 99);
			r.data_byte    = 8'($urandom_range(0, 255));
			r.load_address = 16'($urandom_range(0, 65535));
			if (pick < 86) begin
				r.action = ACT_DATA;
			end else if (pick < 93) begin
				r.action = ACT_ADDR;
				if ($urandom_range(0, 4) == 0) begin
					r.load_address = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
				end
			end else if (pick < 97) begin
				r.action = ACT_EOF;
			end else begin
				r.action = ACT_EXT;
			end
			pend_req.push_back(r);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		if (idx == REG_RECORD_LENGTH) begin
			len_reg = val;
		end else if (idx == REG_EOF_STYLE) begin
			eof_reg = val[0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// all requests taken and all text seen, plus a margin for silent data bytes
	task automatic wait_idle();
		while (pend_req.size() != 0 || in_valid || exp_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request driver. The expectation for a request is queued when the request
	// is first offered, before its handshake completes.
	always @(negedge clk) begin
		if (in_valid && !in_taken) begin
			in_valid <= 1'b1;
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap   <= in_gap - 1;
		end else if (pend_req.size() != 0) begin
			in_item  <= pend_req[0];
			encode_request(pend_req[0]);
			void'(pend_req.pop_front());
			in_valid <= 1'b1;
			in_gap   <= steady ? 0 : gap_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver stalls, with one long hold-off on request.
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			rx_wait   <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (rx_wait > 0) begin
			rx_wait   <= rx_wait - 1;
			out_stall <= 1'b1;
		end else if (!steady && $urandom_range(0, 3) == 0) begin
			rx_wait   <= gap_len();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				n_reqs++;
			end
			if (out_valid && !out_stall) begin
				n_chars++;
				if (exp_chars.size() == 0) begin
					log_error($sformatf("unexpected character %02h last %0b",
						out_item.character, out_item.last_of_run));
				end else begin
					want = exp_chars.pop_front();
					if (out_item.character !== want.character ||
							out_item.last_of_run !== want.last_of_run) begin
						log_error($sformatf("got character %02h last %0b, expected %02h last %0b",
							out_item.character, out_item.last_of_run,
							want.character, want.last_of_run));
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: %0d cycles without a handshake", idle_cycles);
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		logic [4:0] lens [PHASES];
		logic       eofs [PHASES];
		lens = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd9, 5'd16, 5'd2};
		eofs = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		lens[PHASES-1] = 5'($urandom_range(0, 31));
		eofs[PHASES-1] = 1'($urandom_range(0, 1));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset config: length 16, plain end string
		queue_req(ACT_EOF, 8'h00, 16'h0000);
		queue_req(ACT_EXT, 8'h00, 16'h0000);
		queue_req(ACT_ADDR, 8'h00, 16'hFFFF);
		queue_req(ACT_DATA, 8'h00, 16'h0000);
		queue_req(ACT_DATA, 8'hFF, 16'h0000);
		queue_req(ACT_DATA, 8'h5A, 16'h0000);
		queue_req(ACT_EXT, 8'h00, 16'h0000);
		queue_req(ACT_DATA, 8'hA5, 16'h0000);
		queue_req(ACT_DATA, 8'h3C, 16'h0000);
		queue_req(ACT_EOF, 8'h00, 16'h0000);
		queue_req(ACT_ADDR, 8'h00, 16'h8000);
		queue_req(ACT_ADDR, 8'h00, 16'h00FF);
		queue_req(ACT_DATA, 8'h01, 16'h0000);
		queue_req(ACT_DATA, 8'h02, 16'h0000);
		queue_req(ACT_DATA, 8'h80, 16'h0000);
		queue_req(ACT_DATA, 8'h7F, 16'h0000);
		wait_idle();

		// length lowered below a partial record, standard end string
		write_reg(REG_RECORD_LENGTH, 5'd2);
		write_reg(REG_EOF_STYLE, 5'd1);
		queue_req(ACT_DATA, 8'h10, 16'h0000);
		queue_req(ACT_DATA, 8'h20, 16'h0000);
		queue_req(ACT_DATA, 8'h30, 16'h0000);
		queue_req(ACT_EOF, 8'h00, 16'h0000);
		wait_idle();

		// zero length acts as one
		write_reg(REG_RECORD_LENGTH, 5'd0);
		queue_req(ACT_DATA, 8'hEE, 16'h0000);
		queue_req(ACT_ADDR, 8'h00, 16'h1234);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_RECORD_LENGTH, lens[p]);
			write_reg(REG_EOF_STYLE, {4'b0, eofs[p]});
			steady = (p == 3);
			queue_random(55);
			if (p == 2) begin
				hold_req = 1'b1;
			end
			wait_idle();
		end

		if (exp_chars.size() != 0) begin
			log_error($sformatf("%0d expected characters never arrived", exp_chars.size()));
		end
		$display("summary: %0d requests, %0d characters checked, %0d errors",
			n_reqs, n_chars, n_errors);
		$display("summary: %0d data records, %0d end-of-file, %0d extended; lengths 0..31",
			n_records, n_eof, n_ext);
		if (n_errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
